### hdl/lmtp_pkg.sv
// Shared constants, codes and types for the LED matrix transition pixel compositor.
// Used by lmtp_scale and led_matrix_transition_pixel. No dependencies.
package lmtp_pkg;

  // Grid geometry and fade depth.
  localparam int GRID_ROWS  = 13;
  localparam int GRID_COLS  = 13;
  localparam int FADE_STEPS = 20;
  localparam int HEART_FULL = 255;

  // Internal widths: grid coordinates (up to 127) and the unmasked LED index.
  localparam int COORD_W = 7;
  localparam int IDX_W   = 13;

  // Reciprocal scaling: x / den is taken as (x * floor(2^16 / den)) >> 16 plus a
  // correction of at most one.
  localparam int RECIP_SHIFT = 16;
  localparam int RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] FADE_RECIP  = RECIP_W'((1 << RECIP_SHIFT) / FADE_STEPS);
  localparam logic [RECIP_W-1:0] HEART_RECIP = RECIP_W'((1 << RECIP_SHIFT) / HEART_FULL);
  localparam logic [7:0]         FADE_DEN    = 8'(FADE_STEPS);
  localparam logic [7:0]         HEART_DEN   = 8'(HEART_FULL);

  // Effect codes; the two unused codes behave as fade.
  typedef enum logic [2:0] {
    KIND_FADE      = 3'd0,
    KIND_WIPE_LR   = 3'd1,
    KIND_WIPE_RL   = 3'd2,
    KIND_RAIN      = 3'd3,
    KIND_RIPPLE    = 3'd4,
    KIND_HEARTBEAT = 3'd5
  } kind_t;

  // Configuration register indexes.
  localparam logic CFG_CENTER_ROW = 1'b0;
  localparam logic CFG_CENTER_COL = 1'b1;

  // Stage load enables handed to the scaler lanes.
  typedef struct packed {
    logic ld2;
    logic ld3;
  } lmtp_ld_t;

endpackage

### hdl/lmtp_scale.sv
// One color channel divider: product / den by reciprocal multiply and correction.
// Takes the stage-one product, returns the quotient two stages later. Uses lmtp_pkg.
module lmtp_scale (
  input  logic             clk,
  input  lmtp_pkg::lmtp_ld_t ld,
  input  logic [15:0]      prod,
  input  logic             heart,
  output logic [7:0]       quot
);
  import lmtp_pkg::*;

  logic [RECIP_W-1:0]         recip;
  logic [RECIP_W+15:0]        est;
  logic [15:0]                x_s2_r;
  logic [7:0]                 q0_s2_r;
  logic                       heart_s2_r;
  logic [7:0]                 den_s2;
  logic [15:0]                back;
  logic [15:0]                rem;
  logic [7:0]                 quot_nxt;
  logic [7:0]                 quot_r;

  // Stage two: the estimate never overshoots and is at most one short.
  assign recip = heart ? HEART_RECIP : FADE_RECIP;
  assign est   = (RECIP_W + 16)'(prod) * (RECIP_W + 16)'(recip);

  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      x_s2_r     <= prod;
      q0_s2_r    <= est[RECIP_SHIFT +: 8];
      heart_s2_r <= heart;
    end
  end

  // Stage three: remainder check adds the missing one.
  assign den_s2   = heart_s2_r ? HEART_DEN : FADE_DEN;
  assign back     = 16'(q0_s2_r) * 16'(den_s2);
  assign rem      = x_s2_r - back;
  assign quot_nxt = (rem >= 16'(den_s2)) ? q0_s2_r + 8'd1 : q0_s2_r;

  always_ff @(posedge clk) begin
    if (ld.ld3) begin
      quot_r <= quot_nxt;
    end
  end

  assign quot = quot_r;

endmodule

### hdl/led_matrix_transition_pixel.sv
// Top level of the per-pixel transition compositor for a serpentine LED grid.
// Depends on lmtp_pkg and on three lmtp_scale channel dividers.
//
//   channel   direction  handshake              payload
//   in_       in         in_valid / in_stall    kind, phase, step, row, col, 3 colors
//   out_      out        out_valid / out_stall  led_index, pixel_color
//   cfg_      in         cfg_we                 cfg_index, cfg_data (ripple center)
//
// One beat enters per clock while in_stall is low; the three-stage pipeline
// around the reciprocal channel scaler carries each beat to the output.
// Reset (synchronous, rst_n low) empties the pipeline and sets the center to 6,6.
// A stalled output holds its beat; stages behind it keep filling bubbles, and
// in_stall rises only when all three stages hold beats and the output is stalled.
module led_matrix_transition_pixel (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic        in_phase,
  input  logic [7:0]  in_step,
  input  logic [3:0]  in_row,
  input  logic [3:0]  in_col,
  input  logic [23:0] in_old_color,
  input  logic [23:0] in_new_color,
  input  logic [23:0] in_current_color,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_led_index,
  output logic [23:0] out_pixel_color
);
  import lmtp_pkg::*;

  localparam logic [COORD_W-1:0] LAST_ROW = COORD_W'(GRID_ROWS - 1);
  localparam logic [COORD_W-1:0] LAST_COL = COORD_W'(GRID_COLS - 1);

  // Configuration registers.
  logic [3:0] center_row_r;
  logic [3:0] center_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_row_r <= 4'd6;
      center_col_r <= 4'd6;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_ROW: center_row_r <= cfg_data;
        CFG_CENTER_COL: center_col_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline control: each stage takes a beat when it is empty or its
  // successor takes the one it holds.
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;
  lmtp_ld_t ld;

  assign rdy3     = !v3_r || !out_stall;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_stall = !rdy1;
  assign ld.ld2   = rdy2 && v1_r;
  assign ld.ld3   = rdy3 && v2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Stage one: saturate the position, decide whether the pixel is hit, form
  // the color for the non-scaling effects and the channel products.
  kind_t              kind;
  logic [3:0]         row_c, col_c;
  logic [COORD_W-1:0] prow, col_x;
  logic [3:0]         drow, dcol;
  logic [4:0]         ripple_d;
  logic [23:0]        src;
  logic [7:0]         num;
  logic               hit, scaled, heart;
  logic [23:0]        plain;

  assign kind  = kind_t'(in_kind);
  assign row_c = ({3'b0, in_row} > LAST_ROW) ? LAST_ROW[3:0] : in_row;
  assign col_c = ({3'b0, in_col} > LAST_COL) ? LAST_COL[3:0] : in_col;
  assign prow  = LAST_ROW - COORD_W'(row_c);
  // Odd physical rows run right to left.
  assign col_x = prow[0] ? LAST_COL - COORD_W'(col_c) : COORD_W'(col_c);

  assign drow     = (row_c >= center_row_r) ? row_c - center_row_r : center_row_r - row_c;
  assign dcol     = (col_c >= center_col_r) ? col_c - center_col_r : center_col_r - col_c;
  assign ripple_d = 5'(drow) + 5'(dcol);
  assign src      = in_phase ? in_new_color : in_old_color;

  always_comb begin
    hit    = 1'b0;
    scaled = 1'b0;
    heart  = 1'b0;
    unique case (kind)
      KIND_WIPE_LR:   hit = ({4'b0, col_c} <= in_step);
      KIND_WIPE_RL:   hit = ({4'b0, col_c} >= in_step);
      KIND_RAIN:      hit = ({4'b0, row_c} <= in_step) && (!in_phase || in_new_color != 24'd0);
      KIND_RIPPLE:    hit = in_phase ? ({3'b0, ripple_d} >= in_step)
                                     : ({3'b0, ripple_d} <= in_step);
      KIND_HEARTBEAT: begin
        scaled = 1'b1;
        heart  = 1'b1;
      end
      default:        scaled = 1'b1;
    endcase
  end

  // Fade clamps the step to its denominator; heartbeat uses it as is.
  assign num   = (heart || in_step <= FADE_DEN) ? in_step : FADE_DEN;
  assign plain = hit ? (in_phase ? in_new_color : 24'd0) : in_current_color;

  logic [15:0]        prod_r_s1_r, prod_g_s1_r, prod_b_s1_r;
  logic               heart_s1_r, scaled_s1_r;
  logic [23:0]        plain_s1_r;
  logic [COORD_W-1:0] prow_s1_r, colx_s1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      prod_r_s1_r <= 16'(src[23:16]) * 16'(num);
      prod_g_s1_r <= 16'(src[15:8]) * 16'(num);
      prod_b_s1_r <= 16'(src[7:0]) * 16'(num);
      heart_s1_r  <= heart;
      scaled_s1_r <= scaled;
      plain_s1_r  <= plain;
      prow_s1_r   <= prow;
      colx_s1_r   <= col_x;
    end
  end

  // Stage two: serpentine index. Stages two and three also run the dividers.
  logic [IDX_W-1:0] idx_full;
  logic [7:0]       idx_s2_r, idx_s3_r;
  logic             scaled_s2_r, scaled_s3_r;
  logic [23:0]      plain_s2_r, plain_s3_r;

  assign idx_full = IDX_W'(prow_s1_r) * IDX_W'(GRID_COLS) + IDX_W'(colx_s1_r);

  always_ff @(posedge clk) begin
    if (ld.ld2) begin
      idx_s2_r    <= idx_full[7:0];
      scaled_s2_r <= scaled_s1_r;
      plain_s2_r  <= plain_s1_r;
    end
    if (ld.ld3) begin
      idx_s3_r    <= idx_s2_r;
      scaled_s3_r <= scaled_s2_r;
      plain_s3_r  <= plain_s2_r;
    end
  end

  logic [7:0] q_r, q_g, q_b;

  lmtp_scale u_scale_r (.clk(clk), .ld(ld), .prod(prod_r_s1_r), .heart(heart_s1_r), .quot(q_r));
  lmtp_scale u_scale_g (.clk(clk), .ld(ld), .prod(prod_g_s1_r), .heart(heart_s1_r), .quot(q_g));
  lmtp_scale u_scale_b (.clk(clk), .ld(ld), .prod(prod_b_s1_r), .heart(heart_s1_r), .quot(q_b));

  // Stage three output.
  assign out_valid       = v3_r;
  assign out_led_index   = idx_s3_r;
  assign out_pixel_color = scaled_s3_r ? {q_r, q_g, q_b} : plain_s3_r;

  // The input only backs up when every stage holds a beat.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_stall))
    else $error("input stalled with a free pipeline stage");

  // An accepted beat lands in stage one.
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted beat missing from stage one");

  // A beat moving out of stage two becomes the output beat.
  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && rdy3) |=> out_valid)
    else $error("beat lost between stage two and the output");

  // The index stays on the grid whenever it fits in eight bits.
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((GRID_ROWS * GRID_COLS > 256) ||
                   (32'(out_led_index) < GRID_ROWS * GRID_COLS)))
    else $error("LED index beyond the grid");

endmodule

### sim/tb_top.sv
// Self-checking testbench for the LED matrix transition pixel compositor.
// Depends on lmtp_pkg and led_matrix_transition_pixel. It predicts every pixel
// beat with its own compositor model and compares each result in arrival order.
module tb_top;
  import lmtp_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [2:0]  kind;
    logic        phase;
    logic [7:0]  step;
    logic [3:0]  row;
    logic [3:0]  col;
    logic [23:0] old_color;
    logic [23:0] new_color;
    logic [23:0] current_color;
  } pixel_t;

  typedef struct packed {
    logic [7:0]  led_index;
    logic [23:0] pixel_color;
  } lit_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        cfg_we           = 1'b0;
  logic        cfg_index        = CFG_CENTER_ROW;
  logic [3:0]  cfg_data         = 4'd0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [2:0]  in_kind          = 3'd0;
  logic        in_phase         = 1'b0;
  logic [7:0]  in_step          = 8'd0;
  logic [3:0]  in_row           = 4'd0;
  logic [3:0]  in_col           = 4'd0;
  logic [23:0] in_old_color     = 24'd0;
  logic [23:0] in_new_color     = 24'd0;
  logic [23:0] in_current_color = 24'd0;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [7:0]  out_led_index;
  logic [23:0] out_pixel_color;

  // The predictor's copy of the ripple center registers.
  int ripple_row = 6;
  int ripple_col = 6;

  lit_t lit_expect_q[$];
  int   mismatch_count = 0;
  int   checked_count  = 0;
  int   sent_count     = 0;
  int   centre_writes  = 0;
  int   kind_sent[8];
  int   cycle_count    = 0;
  int   stall_hold     = 0;
  bit   quiet          = 1'b0;

  led_matrix_transition_pixel dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_kind          (in_kind),
    .in_phase         (in_phase),
    .in_step          (in_step),
    .in_row           (in_row),
    .in_col           (in_col),
    .in_old_color     (in_old_color),
    .in_new_color     (in_new_color),
    .in_current_color (in_current_color),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_led_index    (out_led_index),
    .out_pixel_color  (out_pixel_color)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Scales each of the three color bytes by num/den with truncation.
  function automatic logic [23:0] scale_rgb(logic [23:0] color, int num, int den);
    logic [23:0] scaled;
    int i;
    for (i = 0; i < 3; i++) begin
      scaled[8*i +: 8] = 8'(int'(color[8*i +: 8]) * num / den);
    end
    return scaled;
  endfunction

  // Works out the LED index and color that one pixel beat must produce.
  function automatic lit_t predict_lit(pixel_t p);
    int r, c, prow, idx, ripple_d, level;
    logic [23:0] src;
    logic hit;
    lit_t res;
    // Coordinates past the grid edge are pinned to the last row or column.
    r = (p.row > GRID_ROWS - 1) ? GRID_ROWS - 1 : int'(p.row);
    c = (p.col > GRID_COLS - 1) ? GRID_COLS - 1 : int'(p.col);
    // Physical rows count from the bottom and odd ones run right to left.
    prow = GRID_ROWS - 1 - r;
    idx = (prow % 2 == 0) ? prow * GRID_COLS + c : prow * GRID_COLS + (GRID_COLS - 1 - c);
    src = p.phase ? p.new_color : p.old_color;
    hit = 1'b0;
    res.led_index = 8'(idx);
    res.pixel_color = p.current_color;
    case (p.kind)
      KIND_WIPE_LR: hit = (c <= int'(p.step));
      KIND_WIPE_RL: hit = (c >= int'(p.step));
      KIND_RAIN:    hit = (r <= int'(p.step)) && (!p.phase || p.new_color != 24'd0);
      KIND_RIPPLE: begin
        ripple_d = ((r > ripple_row) ? r - ripple_row : ripple_row - r) +
                   ((c > ripple_col) ? c - ripple_col : ripple_col - c);
        hit = p.phase ? (ripple_d >= int'(p.step)) : (ripple_d <= int'(p.step));
      end
      KIND_HEARTBEAT: res.pixel_color = scale_rgb(src, int'(p.step), HEART_FULL);
      default: begin
        // Fade, and the two unused codes which fall back to it.
        level = (p.step > FADE_STEPS) ? FADE_STEPS : int'(p.step);
        res.pixel_color = scale_rgb(src, level, FADE_STEPS);
      end
    endcase
    if (hit) res.pixel_color = p.phase ? p.new_color : 24'd0;
    return res;
  endfunction

  function automatic pixel_t mk(int kind, int phase, int step, int row, int col,
                                logic [23:0] old_c, logic [23:0] new_c, logic [23:0] cur_c);
    pixel_t p;
    p.kind = 3'(kind);
    p.phase = 1'(phase);
    p.step = 8'(step);
    p.row = 4'(row);
    p.col = 4'(col);
    p.old_color = old_c;
    p.new_color = new_c;
    p.current_color = cur_c;
    return p;
  endfunction

  function automatic logic [23:0] random_color();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return 24'h000000;
    if (pick == 1) return 24'hFFFFFF;
    return 24'($urandom);
  endfunction

  // A random pixel; the step range is chosen to sit near the thresholds that
  // matter for the effect, with a share of full-range steps on top.
  function automatic pixel_t random_pixel(int forced_kind);
    pixel_t p;
    int k;
    if (forced_kind >= 0) k = forced_kind;
    else if ($urandom_range(0, 19) == 0) k = $urandom_range(6, 7);
    else k = $urandom_range(0, 5);
    p.kind = 3'(k);
    p.phase = 1'($urandom_range(0, 1));
    p.row = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(13, 15) : $urandom_range(0, 12));
    p.col = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(13, 15) : $urandom_range(0, 12));
    case (p.kind)
      KIND_HEARTBEAT: p.step = 8'($urandom_range(0, 255));
      KIND_WIPE_LR, KIND_WIPE_RL, KIND_RAIN: p.step = 8'($urandom_range(0, 15));
      KIND_RIPPLE: p.step = 8'($urandom_range(0, 30));
      default: p.step = 8'($urandom_range(0, 24));
    endcase
    if ($urandom_range(0, 9) == 0) p.step = 8'($urandom_range(0, 255));
    p.old_color = random_color();
    p.new_color = random_color();
    p.current_color = random_color();
    return p;
  endfunction

  // Presents one pixel beat and holds it until the block takes it. Valid is
  // left high afterwards so back-to-back beats follow without a gap.
  task automatic send_pixel(pixel_t p);
    int gap;
    gap = quiet ? 0 : idle_length();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= p.kind;
    in_phase         <= p.phase;
    in_step          <= p.step;
    in_row           <= p.row;
    in_col           <= p.col;
    in_old_color     <= p.old_color;
    in_new_color     <= p.new_color;
    in_current_color <= p.current_color;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lit_expect_q.push_back(predict_lit(p));
    sent_count++;
    kind_sent[p.kind]++;
  endtask

  // Drops valid and waits until every predicted beat has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (lit_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register writes happen only with the pipeline empty.
  task automatic write_centre(int row_val, int col_val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CENTER_ROW;
    cfg_data  <= 4'(row_val);
    @(posedge clk);
    cfg_index <= CFG_CENTER_COL;
    cfg_data  <= 4'(col_val);
    @(posedge clk);
    cfg_we <= 1'b0;
    ripple_row = row_val;
    ripple_col = col_val;
    centre_writes++;
  endtask

  task automatic test_fade_and_heartbeat();
    send_pixel(mk(KIND_FADE, 0, 0, 0, 0, 24'hFFFFFF, 24'h123456, 24'hABCDEF));
    send_pixel(mk(KIND_FADE, 1, 20, 12, 12, 24'h000000, 24'hFFFFFF, 24'h000000));
    send_pixel(mk(KIND_FADE, 0, 255, 15, 15, 24'h123456, 24'hFFFFFF, 24'h555555));
    send_pixel(mk(KIND_FADE, 1, 7, 13, 3, 24'h000000, 24'h80FF01, 24'hFFFFFF));
    send_pixel(mk(6, 0, 13, 4, 14, 24'hFEDCBA, 24'h0F0F0F, 24'h000000));
    send_pixel(mk(7, 1, 255, 1, 1, 24'h000000, 24'hFFFFFF, 24'h777777));
    send_pixel(mk(KIND_HEARTBEAT, 0, 255, 2, 8, 24'hFFFFFF, 24'h000000, 24'h000000));
    send_pixel(mk(KIND_HEARTBEAT, 1, 0, 9, 5, 24'h000000, 24'hFFFFFF, 24'hFFFFFF));
    send_pixel(mk(KIND_HEARTBEAT, 1, 128, 7, 11, 24'h000000, 24'hA5C3E7, 24'h000000));
  endtask

  task automatic test_wipes_rain_ripple();
    send_pixel(mk(KIND_WIPE_LR, 0, 5, 3, 5, 24'h111111, 24'h222222, 24'h333333));
    send_pixel(mk(KIND_WIPE_LR, 1, 4, 3, 5, 24'h111111, 24'h222222, 24'h333333));
    send_pixel(mk(KIND_WIPE_LR, 1, 255, 0, 15, 24'h000000, 24'hFFFFFF, 24'h010101));
    send_pixel(mk(KIND_WIPE_RL, 0, 12, 6, 12, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF));
    send_pixel(mk(KIND_WIPE_RL, 1, 13, 6, 15, 24'h000000, 24'hC0FFEE, 24'h0A0B0C));
    send_pixel(mk(KIND_WIPE_RL, 1, 0, 11, 0, 24'h000000, 24'hC0FFEE, 24'h0A0B0C));
    send_pixel(mk(KIND_RAIN, 0, 3, 3, 2, 24'h999999, 24'h000000, 24'h444444));
    // A black pixel of the new frame is never revealed by rain.
    send_pixel(mk(KIND_RAIN, 1, 3, 2, 2, 24'h999999, 24'h000000, 24'h444444));
    send_pixel(mk(KIND_RAIN, 1, 3, 4, 7, 24'h999999, 24'h00FF00, 24'h444444));
    send_pixel(mk(KIND_RAIN, 1, 0, 0, 9, 24'h999999, 24'h000001, 24'h444444));
    send_pixel(mk(KIND_RIPPLE, 0, 0, 6, 6, 24'hFFFFFF, 24'hFFFFFF, 24'h123123));
    send_pixel(mk(KIND_RIPPLE, 1, 0, 0, 12, 24'hFFFFFF, 24'h00FFFF, 24'h123123));
    send_pixel(mk(KIND_RIPPLE, 0, 11, 0, 0, 24'hFFFFFF, 24'h00FFFF, 24'h123123));
    send_pixel(mk(KIND_RIPPLE, 1, 12, 15, 15, 24'hFFFFFF, 24'h00FFFF, 24'h123123));
    send_pixel(mk(KIND_RIPPLE, 1, 255, 3, 9, 24'hFFFFFF, 24'h00FFFF, 24'h123123));
  endtask

  // Ripple distances with the center at the corners and past the grid edge.
  task automatic test_ripple_centres();
    int centres[5][2] = '{'{0, 0}, '{12, 12}, '{15, 15}, '{0, 15}, '{15, 0}};
    int n;
    foreach (centres[i]) begin
      write_centre(centres[i][0], centres[i][1]);
      for (n = 0; n < 30; n++) send_pixel(random_pixel(KIND_RIPPLE));
    end
  endtask

  // Mixed traffic over several random centers; two bursts run without any
  // idling on either side to keep the pipeline full.
  task automatic test_random_traffic();
    int burst, n;
    for (burst = 0; burst < 7; burst++) begin
      write_centre($urandom_range(0, 15), $urandom_range(0, 15));
      quiet = (burst == 2 || burst == 5);
      for (n = 0; n < 230; n++) send_pixel(random_pixel(-1));
    end
    quiet = 1'b0;
  endtask

  // Receiver side: the output stall toggles in runs of random length.
  always @(posedge clk) begin
    if (quiet) begin
      out_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      out_stall <= ($urandom_range(0, 3) == 0);
      stall_hold <= idle_length();
    end
  end

  // Every accepted result beat is matched against the oldest prediction.
  always @(posedge clk) begin
    lit_t want;
    if (rst_n && out_valid && !out_stall) begin
      checked_count++;
      if (lit_expect_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("ERROR: unexpected result index %0d color %06h",
                   out_led_index, out_pixel_color);
      end else begin
        want = lit_expect_q.pop_front();
        if (out_led_index !== want.led_index || out_pixel_color !== want.pixel_color) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("ERROR: result %0d: index exp %0d got %0d, color exp %06h got %06h",
                     checked_count, want.led_index, out_led_index,
                     want.pixel_color, out_pixel_color);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: timeout with %0d results outstanding", lit_expect_q.size());
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : main_seq
    foreach (kind_sent[k]) kind_sent[k] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_fade_and_heartbeat();
    test_wipes_rain_ripple();
    test_ripple_centres();
    test_random_traffic();
    drain();
    if (lit_expect_q.size() != 0) mismatch_count++;
    $display("Sent %0d pixel beats (fade %0d, wipes %0d, rain %0d, ripple %0d, heartbeat %0d,",
             sent_count, kind_sent[0], kind_sent[1] + kind_sent[2], kind_sent[3],
             kind_sent[4], kind_sent[5]);
    $display("  unused codes %0d) over %0d ripple centers; %0d results checked, %0d bad.",
             kind_sent[6] + kind_sent[7], centre_writes + 1, checked_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/lmtp_pkg.sv
hdl/lmtp_scale.sv
hdl/led_matrix_transition_pixel.sv
sim/tb_top.sv
